[rtl/call_capture_segmenter_core_assert.svh]
// assertion macros for the call capture segmenter checker
// relies on clk and arst_n being visible in the scope that uses them
`ifndef CALL_CAPTURE_SEGMENTER_CORE_ASSERT_SVH
`define CALL_CAPTURE_SEGMENTER_CORE_ASSERT_SVH

// clocked assertion, held off while reset is asserted
`define CCS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// clocked assertion that is also checked during reset
`define CCS_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/ccs_pkg.sv]
// shared types, constants and helpers of the call capture segmenter
// no dependencies
package ccs_pkg;

	localparam int CALL_SLOTS   = 64;
	localparam int DESC_COUNT   = 16;
	localparam int PRE_SLOTS    = 4;
	localparam int START_MARGIN = 2;

	localparam int CALL_W     = $clog2(CALL_SLOTS);
	localparam int DESC_W     = $clog2(DESC_COUNT);
	localparam int PRE_W      = (PRE_SLOTS > 1) ? $clog2(PRE_SLOTS) : 1;
	localparam int PRE_FILL_W = $clog2(PRE_SLOTS + 1);
	localparam int USED_W     = $clog2(CALL_SLOTS + PRE_SLOTS + 1);
	localparam int LEN_W      = 9;
	localparam int STEP_W     = $clog2(PRE_SLOTS + 2);

	typedef enum logic [2:0] {
		ACT_STORE_PRE = 3'd0,
		ACT_COPY      = 3'd1,
		ACT_STORE     = 3'd2,
		ACT_CLOSED    = 3'd3,
		ACT_DROPPED   = 3'd4,
		ACT_RELEASED  = 3'd5,
		ACT_NONE      = 3'd6
	} act_t;

	typedef enum logic {
		CMD_FRAME   = 1'b0,
		CMD_RELEASE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		CFG_START_TH = 2'd0,
		CFG_STOP_TH  = 2'd1,
		CFG_AFTER    = 2'd2,
		CFG_MAX      = 2'd3
	} cfg_idx_t;

	typedef enum logic [2:0] {
		J_PRE,
		J_START,
		J_STORE,
		J_CLOSE,
		J_DROP,
		J_REL,
		J_NONE
	} job_kind_t;

	typedef struct packed {
		logic        command;
		logic [11:0] envelope;
		logic [31:0] time_ms;
	} in_item_t;

	typedef struct packed {
		act_t        action;
		logic [1:0]  src_slot;
		logic [5:0]  dst_slot;
		logic [15:0] sample_number;
		logic [3:0]  call_index;
		logic [8:0]  call_length;
		logic [31:0] start_time;
		logic        last;
	} out_item_t;

	typedef struct packed {
		logic [11:0] start_th;
		logic [11:0] stop_th;
		logic [7:0]  after;
		logic [7:0]  max_len;
	} cfg_t;

	// one classified command, expanded into results by the back end
	typedef struct packed {
		job_kind_t             kind;
		logic [PRE_FILL_W-1:0] n_copy;
		logic [PRE_W-1:0]      src_first;
		logic [CALL_W-1:0]     slot;
		logic [CALL_W-1:0]     start;
		logic [15:0]           sn;
		logic [DESC_W-1:0]     ci;
		logic [LEN_W-1:0]      len;
		logic [31:0]           tstamp;
		logic                  store_first;
	} job_t;

	typedef struct packed {
		logic valid;
		logic full;
	} q_stat_t;

	// wrap helpers: argument is known to stay below twice the ring size
	function automatic logic [CALL_W-1:0] wrap_call(input logic [CALL_W:0] v);
		logic [CALL_W:0] r;
		r = (v >= (CALL_W+1)'(CALL_SLOTS)) ? v - (CALL_W+1)'(CALL_SLOTS) : v;
		return r[CALL_W-1:0];
	endfunction

	function automatic logic [DESC_W-1:0] wrap_desc(input logic [DESC_W:0] v);
		logic [DESC_W:0] r;
		r = (v >= (DESC_W+1)'(DESC_COUNT)) ? v - (DESC_W+1)'(DESC_COUNT) : v;
		return r[DESC_W-1:0];
	endfunction

	function automatic logic [PRE_W-1:0] wrap_pre(input logic [PRE_FILL_W:0] v);
		logic [PRE_FILL_W:0] r;
		r = (v >= (PRE_FILL_W+1)'(PRE_SLOTS)) ? v - (PRE_FILL_W+1)'(PRE_SLOTS) : v;
		return r[PRE_W-1:0];
	endfunction

endpackage

[rtl/ccs_front.sv]
// front end: accepts commands, keeps ring and call state, classifies into jobs
// depends on ccs_pkg
module ccs_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ccs_pkg::in_item_t in_data,
	input  logic              cfg_valid,
	input  logic [1:0]        cfg_index,
	input  logic [11:0]       cfg_data,
	input  ccs_pkg::q_stat_t  q_stat,
	output logic              push,
	output ccs_pkg::job_t     push_job
);

	typedef enum logic {
		S_IDLE,
		S_REL
	} state_t;

	typedef struct packed {
		logic [ccs_pkg::CALL_W-1:0] start;
		logic [ccs_pkg::LEN_W-1:0]  len;
		logic [31:0]                tstamp;
	} desc_t;

	state_t state_q;
	logic   push_q;
	ccs_pkg::job_t job_q;
	ccs_pkg::cfg_t cfg_q;

	logic                           in_call_q;
	logic [7:0]                     hang_q;
	logic [ccs_pkg::PRE_W-1:0]      pre_wr_q;
	logic [ccs_pkg::PRE_FILL_W-1:0] pre_fill_q;
	logic [ccs_pkg::CALL_W-1:0]     cws_q;
	logic [ccs_pkg::USED_W-1:0]     used_q;
	logic [ccs_pkg::DESC_W-1:0]     head_q;
	logic [ccs_pkg::DESC_W-1:0]     tail_q;
	logic [15:0]                    frame_q;
	logic [ccs_pkg::CALL_W-1:0]     cur_start_q;
	logic [ccs_pkg::LEN_W-1:0]      cur_len_q;
	logic [31:0]                    cur_time_q;

	desc_t desc_mem [ccs_pkg::DESC_COUNT];
	desc_t rd_q;

	logic accept;

	// next-state values for an accepted command
	ccs_pkg::job_t                  job_n;
	ccs_pkg::job_t                  rel_job;
	logic                           push_n;
	logic                           in_call_n;
	logic [7:0]                     hang_n;
	logic [ccs_pkg::PRE_W-1:0]      pre_wr_n;
	logic [ccs_pkg::PRE_FILL_W-1:0] pre_fill_n;
	logic [ccs_pkg::CALL_W-1:0]     cws_n;
	logic [ccs_pkg::USED_W-1:0]     used_n;
	logic [ccs_pkg::DESC_W-1:0]     head_n;
	logic [ccs_pkg::DESC_W-1:0]     tail_n;
	logic [15:0]                    frame_n;
	logic [ccs_pkg::CALL_W-1:0]     cur_start_n;
	logic [ccs_pkg::LEN_W-1:0]      cur_len_n;
	logic [31:0]                    cur_time_n;
	logic                           to_rel;
	logic                           mem_we;
	logic                           mem_re;

	logic [15:0]                    fc_inc;
	logic [ccs_pkg::DESC_W-1:0]     head_inc;
	logic [ccs_pkg::DESC_W-1:0]     tail_inc;
	logic                           start_ok;
	logic                           cont_ok;
	logic [ccs_pkg::PRE_W-1:0]      first_src;
	logic                           room;
	logic [ccs_pkg::LEN_W-1:0]      used_ext;

	assign in_stall = (state_q != S_IDLE) || push_q || q_stat.full;
	assign accept   = in_valid && !in_stall;
	assign push     = push_q;
	assign push_job = job_q;

	assign fc_inc   = frame_q + 16'd1;
	assign head_inc = ccs_pkg::wrap_desc({1'b0, head_q} + (ccs_pkg::DESC_W+1)'(1));
	assign tail_inc = ccs_pkg::wrap_desc({1'b0, tail_q} + (ccs_pkg::DESC_W+1)'(1));
	assign start_ok = !in_call_q && (in_data.envelope > cfg_q.start_th) &&
		(used_q < ccs_pkg::USED_W'(ccs_pkg::CALL_SLOTS - ccs_pkg::START_MARGIN));
	assign room     = used_q < ccs_pkg::USED_W'(ccs_pkg::CALL_SLOTS);
	assign cont_ok  = ((in_data.envelope > cfg_q.stop_th) || (hang_q < cfg_q.after)) &&
		room && (cur_len_q < {1'b0, cfg_q.max_len});
	assign first_src = ccs_pkg::wrap_pre((ccs_pkg::PRE_FILL_W+1)'(pre_wr_q) +
		(ccs_pkg::PRE_FILL_W+1)'(ccs_pkg::PRE_SLOTS) - (ccs_pkg::PRE_FILL_W+1)'(pre_fill_q));
	assign used_ext = ccs_pkg::LEN_W'(used_q);

	always_comb begin
		job_n       = '0;
		push_n      = 1'b0;
		to_rel      = 1'b0;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		in_call_n   = in_call_q;
		hang_n      = hang_q;
		pre_wr_n    = pre_wr_q;
		pre_fill_n  = pre_fill_q;
		cws_n       = cws_q;
		used_n      = used_q;
		head_n      = head_q;
		tail_n      = tail_q;
		frame_n     = frame_q;
		cur_start_n = cur_start_q;
		cur_len_n   = cur_len_q;
		cur_time_n  = cur_time_q;
		if (in_data.command == ccs_pkg::CMD_RELEASE) begin
			if (head_q == tail_q) begin
				job_n.kind = ccs_pkg::J_NONE;
				push_n     = 1'b1;
			end else begin
				// descriptor read goes out now, the job is formed next cycle
				tail_n = tail_inc;
				mem_re = 1'b1;
				to_rel = 1'b1;
			end
		end else begin
			frame_n  = fc_inc;
			push_n   = 1'b1;
			job_n.sn = fc_inc;
			if (start_ok) begin
				job_n.ci = head_inc;
				if (head_inc == tail_q) begin
					job_n.kind = ccs_pkg::J_DROP;
				end else begin
					job_n.kind      = ccs_pkg::J_START;
					job_n.n_copy    = pre_fill_q;
					job_n.src_first = first_src;
					job_n.slot      = cws_q;
					in_call_n       = 1'b1;
					hang_n          = 8'd0;
					pre_fill_n      = '0;
					cur_start_n     = cws_q;
					cur_time_n      = in_data.time_ms;
					cur_len_n       = ccs_pkg::LEN_W'(pre_fill_q) + ccs_pkg::LEN_W'(1);
					cws_n           = ccs_pkg::wrap_call({1'b0, cws_q} +
						(ccs_pkg::CALL_W+1)'(pre_fill_q) + (ccs_pkg::CALL_W+1)'(1));
					used_n          = used_q + ccs_pkg::USED_W'(pre_fill_q) +
						ccs_pkg::USED_W'(1);
				end
			end else if (in_call_q) begin
				job_n.ci   = head_inc;
				job_n.slot = cws_q;
				if (cont_ok) begin
					job_n.kind = ccs_pkg::J_STORE;
					if (in_data.envelope <= cfg_q.stop_th) begin
						hang_n = hang_q + 8'd1;
					end else if (in_data.envelope > cfg_q.start_th) begin
						hang_n = 8'd0;
					end
					cws_n     = ccs_pkg::wrap_call({1'b0, cws_q} + (ccs_pkg::CALL_W+1)'(1));
					used_n    = used_q + ccs_pkg::USED_W'(1);
					cur_len_n = cur_len_q + ccs_pkg::LEN_W'(1);
				end else begin
					// closing: one last frame if the ring still has room
					job_n.kind        = ccs_pkg::J_CLOSE;
					job_n.store_first = room;
					job_n.start       = cur_start_q;
					job_n.tstamp      = cur_time_q;
					if (room) begin
						cws_n     = ccs_pkg::wrap_call({1'b0, cws_q} +
							(ccs_pkg::CALL_W+1)'(1));
						used_n    = used_q + ccs_pkg::USED_W'(1);
						cur_len_n = cur_len_q + ccs_pkg::LEN_W'(1);
					end
					job_n.len = cur_len_n;
					head_n    = head_inc;
					in_call_n = 1'b0;
					mem_we    = 1'b1;
				end
			end else begin
				job_n.kind = ccs_pkg::J_PRE;
				job_n.slot = ccs_pkg::CALL_W'(pre_wr_q);
				pre_wr_n   = ccs_pkg::wrap_pre((ccs_pkg::PRE_FILL_W+1)'(pre_wr_q) +
					(ccs_pkg::PRE_FILL_W+1)'(1));
				if (pre_fill_q < ccs_pkg::PRE_FILL_W'(ccs_pkg::PRE_SLOTS)) begin
					pre_fill_n = pre_fill_q + ccs_pkg::PRE_FILL_W'(1);
				end
			end
		end
	end

	// released descriptor as a job, from the registered read
	always_comb begin
		rel_job        = '0;
		rel_job.kind   = ccs_pkg::J_REL;
		rel_job.start  = rd_q.start;
		rel_job.ci     = tail_q;
		rel_job.len    = rd_q.len;
		rel_job.tstamp = rd_q.tstamp;
	end

	// descriptor ring
	always_ff @(posedge clk) begin
		if (accept && mem_we) begin
			desc_mem[head_inc] <= '{start: cur_start_q, len: cur_len_n, tstamp: cur_time_q};
		end
		if (accept && mem_re) begin
			rd_q <= desc_mem[tail_inc];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_th <= 12'd1000;
			cfg_q.stop_th  <= 12'd600;
			cfg_q.after    <= 8'd10;
			cfg_q.max_len  <= 8'd200;
		end else if (cfg_valid) begin
			case (cfg_index)
				ccs_pkg::CFG_START_TH: cfg_q.start_th <= cfg_data;
				ccs_pkg::CFG_STOP_TH:  cfg_q.stop_th  <= cfg_data;
				ccs_pkg::CFG_AFTER:    cfg_q.after    <= cfg_data[7:0];
				ccs_pkg::CFG_MAX:      cfg_q.max_len  <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			push_q      <= 1'b0;
			job_q       <= '0;
			in_call_q   <= 1'b0;
			hang_q      <= '0;
			pre_wr_q    <= '0;
			pre_fill_q  <= '0;
			cws_q       <= '0;
			used_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			frame_q     <= '0;
			cur_start_q <= '0;
			cur_len_q   <= '0;
			cur_time_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					push_q <= accept && push_n;
					if (accept) begin
						job_q       <= job_n;
						in_call_q   <= in_call_n;
						hang_q      <= hang_n;
						pre_wr_q    <= pre_wr_n;
						pre_fill_q  <= pre_fill_n;
						cws_q       <= cws_n;
						used_q      <= used_n;
						head_q      <= head_n;
						tail_q      <= tail_n;
						frame_q     <= frame_n;
						cur_start_q <= cur_start_n;
						cur_len_q   <= cur_len_n;
						cur_time_q  <= cur_time_n;
						if (to_rel) begin
							state_q <= S_REL;
						end
					end
				end
				S_REL: begin
					job_q   <= rel_job;
					push_q  <= 1'b1;
					used_q  <= (used_ext > rd_q.len) ?
						ccs_pkg::USED_W'(used_ext - rd_q.len) : '0;
					state_q <= S_IDLE;
				end
				default: begin
					push_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/ccs_queue.sv]
// two-entry job queue between front and back end
// depends on ccs_pkg
module ccs_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ccs_pkg::job_t     push_job,
	input  logic              pop,
	output ccs_pkg::job_t     pop_job,
	output ccs_pkg::q_stat_t  q_stat
);

	ccs_pkg::job_t entry_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] count_q;

	assign pop_job      = entry_q[rd_q];
	assign q_stat.valid = (count_q != 2'd0);
	assign q_stat.full  = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[rtl/ccs_back.sv]
// back end: expands one job into its result transactions, one per cycle while not stalled
// depends on ccs_pkg
module ccs_back (
	input  logic               clk,
	input  logic               arst_n,
	input  ccs_pkg::q_stat_t   q_stat,
	input  ccs_pkg::job_t      pop_job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output ccs_pkg::out_item_t out_data
);

	logic                       busy_q;
	ccs_pkg::job_t              job_q;
	logic [ccs_pkg::STEP_W-1:0] step_q;
	logic                       out_valid_q;
	ccs_pkg::out_item_t         out_q;

	ccs_pkg::out_item_t         res;
	logic                       adv;

	assign pop       = !busy_q && q_stat.valid;
	assign adv       = busy_q && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		res = '0;
		case (job_q.kind)
			ccs_pkg::J_PRE: begin
				res.action        = ccs_pkg::ACT_STORE_PRE;
				res.dst_slot      = 6'(job_q.slot);
				res.sample_number = job_q.sn;
				res.last          = 1'b1;
			end
			ccs_pkg::J_START: begin
				res.call_index = 4'(job_q.ci);
				if (step_q < ccs_pkg::STEP_W'(job_q.n_copy)) begin
					res.action   = ccs_pkg::ACT_COPY;
					res.src_slot = 2'(ccs_pkg::wrap_pre((ccs_pkg::PRE_FILL_W+1)'(job_q.src_first)
						+ (ccs_pkg::PRE_FILL_W+1)'(step_q)));
					res.dst_slot = 6'(ccs_pkg::wrap_call({1'b0, job_q.slot} +
						(ccs_pkg::CALL_W+1)'(step_q)));
				end else begin
					res.action        = ccs_pkg::ACT_STORE;
					res.dst_slot      = 6'(ccs_pkg::wrap_call({1'b0, job_q.slot} +
						(ccs_pkg::CALL_W+1)'(job_q.n_copy)));
					res.sample_number = job_q.sn;
					res.last          = 1'b1;
				end
			end
			ccs_pkg::J_STORE: begin
				res.action        = ccs_pkg::ACT_STORE;
				res.dst_slot      = 6'(job_q.slot);
				res.sample_number = job_q.sn;
				res.call_index    = 4'(job_q.ci);
				res.last          = 1'b1;
			end
			ccs_pkg::J_CLOSE: begin
				res.call_index = 4'(job_q.ci);
				if (job_q.store_first && (step_q == '0)) begin
					res.action        = ccs_pkg::ACT_STORE;
					res.dst_slot      = 6'(job_q.slot);
					res.sample_number = job_q.sn;
				end else begin
					res.action      = ccs_pkg::ACT_CLOSED;
					res.dst_slot    = 6'(job_q.start);
					res.call_length = job_q.len;
					res.start_time  = job_q.tstamp;
					res.last        = 1'b1;
				end
			end
			ccs_pkg::J_DROP: begin
				res.action     = ccs_pkg::ACT_DROPPED;
				res.call_index = 4'(job_q.ci);
				res.last       = 1'b1;
			end
			ccs_pkg::J_REL: begin
				res.action      = ccs_pkg::ACT_RELEASED;
				res.dst_slot    = 6'(job_q.start);
				res.call_index  = 4'(job_q.ci);
				res.call_length = job_q.len;
				res.start_time  = job_q.tstamp;
				res.last        = 1'b1;
			end
			ccs_pkg::J_NONE: begin
				res.action = ccs_pkg::ACT_NONE;
				res.last   = 1'b1;
			end
			default: res.last = 1'b1;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= pop_job;
		end
		if (adv) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (adv) begin
				if (res.last) begin
					busy_q <= 1'b0;
				end else begin
					step_q <= step_q + ccs_pkg::STEP_W'(1);
				end
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/call_capture_segmenter_core.sv]
// top level of the call capture segmenter: front end, job queue, back end
// depends on ccs_pkg, ccs_front, ccs_queue, ccs_back
//
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  in_data   (command, envelope, time_ms)
// out       output     out_valid/out_stall  out_data  (action .. last)
// cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// input stalls while the job register holds a job and after a release until the
// descriptor read has become a job; the back end works on one job at a time and
// sends its results one per cycle while not stalled, pre_fill + 1 for a call start
// job path: job register, queue, back-end job register, output register
// reset clears all control state at once; descriptor storage is not cleared
// out_stall holds the output register; a full two-entry job queue raises in_stall
module call_capture_segmenter_core (
	input  logic               clk,
	input  logic               arst_n,
	// input transactions
	input  logic               in_valid,
	output logic               in_stall,
	input  ccs_pkg::in_item_t  in_data,
	// result transactions
	output logic               out_valid,
	input  logic               out_stall,
	output ccs_pkg::out_item_t out_data,
	// register writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [11:0]        cfg_data
);

	// jobs handed from the front end into the queue
	logic             push;
	ccs_pkg::job_t    push_job;
	// jobs taken by the back end
	logic             pop;
	ccs_pkg::job_t    pop_job;
	ccs_pkg::q_stat_t q_stat;

	// register writes are always taken, they land in the front end
	assign cfg_ready = 1'b1;

	// classification and all ring bookkeeping
	ccs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.cfg_valid(cfg_valid),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_job (push_job)
	);

	// decoupling queue, lets a stalled output not block bookkeeping at once
	ccs_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.pop_job (pop_job),
		.q_stat  (q_stat)
	);

	// result sequencer and output register
	ccs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_stat   (q_stat),
		.pop_job  (pop_job),
		.pop      (pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

[rtl/ccs_checker.sv]
// port-level checker for the call capture segmenter, bound to the top level
// depends on ccs_pkg and call_capture_segmenter_core_assert.svh
`include "call_capture_segmenter_core_assert.svh"

module ccs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input ccs_pkg::in_item_t  in_data,
	input logic               out_valid,
	input logic               out_stall,
	input ccs_pkg::out_item_t out_data,
	input logic               cfg_valid,
	input logic               cfg_ready,
	input logic [1:0]         cfg_index,
	input logic [11:0]        cfg_data
);

	// a stalled result holds
	`CCS_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "result changed under stall")

	// a copy is always followed by more results of the same call start
	`CCS_ASSERT(a_copy_not_last, out_valid && out_data.action == ccs_pkg::ACT_COPY |-> !out_data.last, "copy marked last")

	// results that only ever end a transaction group are always marked last
	`CCS_ASSERT(a_single_last, out_valid && (out_data.action == ccs_pkg::ACT_STORE_PRE || out_data.action == ccs_pkg::ACT_CLOSED || out_data.action == ccs_pkg::ACT_DROPPED || out_data.action == ccs_pkg::ACT_RELEASED || out_data.action == ccs_pkg::ACT_NONE) |-> out_data.last, "final result not marked last")

	// nothing comes out of reset as a result
	`CCS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result during reset")

endmodule

bind call_capture_segmenter_core ccs_checker u_ccs_checker (.*);

[test/call_capture_segmenter_core_checker.sv]
// result checker for the call capture segmenter: tracks the slot rings and descriptors
// on every input transaction and compares each result transaction in order
// depends on ccs_pkg
`timescale 1ns / 1ps

module call_capture_segmenter_core_checker import ccs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      in_stall,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_stall,
	input  out_item_t out_data,
	input  logic      cfg_valid,
	input  logic      cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [11:0] cfg_data,
	output int        fail_count,
	output int        pending
);

	// register copies
	logic [11:0] start_th, stop_th;
	logic [7:0]  after_n, max_len;

	// segmenter state
	bit                 in_call;
	logic [7:0]         hang;
	logic [PRE_W-1:0]   pre_wr;
	int                 pre_fill;
	logic [CALL_W-1:0]  call_wr;
	int                 used;
	logic [DESC_W-1:0]  head, tail;
	logic [15:0]        frame_no;
	logic [CALL_W-1:0]  desc_start [DESC_COUNT];
	int                 desc_len   [DESC_COUNT];
	logic [31:0]        desc_time  [DESC_COUNT];

	out_item_t expected_actions [$];
	out_item_t held;
	bit        have_held;
	out_item_t want;

	task automatic clear_state();
		start_th = 12'd1000;
		stop_th  = 12'd600;
		after_n  = 8'd10;
		max_len  = 8'd200;
		in_call  = 1'b0;
		hang     = '0;
		pre_wr   = '0;
		pre_fill = 0;
		call_wr  = '0;
		used     = 0;
		head     = '0;
		tail     = '0;
		frame_no = '0;
		expected_actions.delete();
	endtask

	// the final result of a transaction is only known at the end, so one is held back
	task automatic note(act_t a, logic [1:0] src, logic [5:0] dst, logic [15:0] sn,
			logic [3:0] ci, logic [8:0] len, logic [31:0] t);
		if (have_held)
			expected_actions.push_back(held);
		held = '{a, src, dst, sn, ci, len, t, 1'b0};
		have_held = 1'b1;
	endtask

	task automatic record_slot(logic [DESC_W-1:0] ci);
		call_wr = CALL_W'((int'(call_wr) + 1) % CALL_SLOTS);
		used++;
		desc_len[ci]++;
	endtask

	task automatic track_command(in_item_t it);
		logic [DESC_W-1:0] nxt;
		int oldest;
		have_held = 1'b0;
		if (it.command == CMD_RELEASE) begin
			if (head == tail) begin
				note(ACT_NONE, '0, '0, '0, '0, '0, '0);
			end else begin
				tail = DESC_W'((int'(tail) + 1) % DESC_COUNT);
				used = (used > desc_len[tail]) ? used - desc_len[tail] : 0;
				note(ACT_RELEASED, '0, desc_start[tail], '0, tail, 9'(desc_len[tail]),
					desc_time[tail]);
			end
		end else begin
			frame_no = frame_no + 16'd1;
			nxt = DESC_W'((int'(head) + 1) % DESC_COUNT);
			if (!in_call && it.envelope > start_th && used < CALL_SLOTS - START_MARGIN) begin
				if (nxt == tail) begin
					note(ACT_DROPPED, '0, '0, '0, nxt, '0, '0);
				end else begin
					in_call = 1'b1;
					desc_start[nxt] = call_wr;
					desc_time[nxt] = it.time_ms;
					desc_len[nxt] = 0;
					hang = '0;
					// pre-trigger frames go first, oldest first
					oldest = (int'(pre_wr) + PRE_SLOTS - pre_fill) % PRE_SLOTS;
					for (int i = 0; i < pre_fill; i++) begin
						note(ACT_COPY, 2'((oldest + i) % PRE_SLOTS), call_wr, '0, nxt, '0, '0);
						record_slot(nxt);
					end
					pre_fill = 0;
					note(ACT_STORE, '0, call_wr, frame_no, nxt, '0, '0);
					record_slot(nxt);
				end
			end else if (in_call) begin
				if ((it.envelope > stop_th || hang < after_n) && used < CALL_SLOTS &&
						desc_len[nxt] < int'(max_len)) begin
					if (it.envelope <= stop_th)
						hang = hang + 8'd1;
					else if (it.envelope > start_th)
						hang = '0;
					note(ACT_STORE, '0, call_wr, frame_no, nxt, '0, '0);
					record_slot(nxt);
				end else begin
					// closing frame is kept only while the ring has room
					if (used < CALL_SLOTS) begin
						note(ACT_STORE, '0, call_wr, frame_no, nxt, '0, '0);
						record_slot(nxt);
					end
					head = nxt;
					in_call = 1'b0;
					note(ACT_CLOSED, '0, desc_start[nxt], '0, nxt, 9'(desc_len[nxt]),
						desc_time[nxt]);
				end
			end else begin
				note(ACT_STORE_PRE, '0, 6'(pre_wr), frame_no, '0, '0, '0);
				pre_wr = PRE_W'((int'(pre_wr) + 1) % PRE_SLOTS);
				if (pre_fill < PRE_SLOTS)
					pre_fill++;
			end
		end
		held.last = 1'b1;
		expected_actions.push_back(held);
	endtask

	function automatic string result_text(out_item_t r);
		return $sformatf("act=%0d src=%0d dst=%0d sn=%0d ci=%0d len=%0d t=%h last=%0d",
			r.action, r.src_slot, r.dst_slot, r.sample_number, r.call_index,
			r.call_length, r.start_time, r.last);
	endfunction

	function automatic bit same_result(out_item_t a, out_item_t b);
		return a.action === b.action && a.src_slot === b.src_slot &&
			a.dst_slot === b.dst_slot && a.sample_number === b.sample_number &&
			a.call_index === b.call_index && a.call_length === b.call_length &&
			a.start_time === b.start_time && a.last === b.last;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_actions.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result: %s", result_text(out_data));
				end else begin
					want = expected_actions.pop_front();
					if (!same_result(want, out_data)) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("result mismatch: expected %s", result_text(want));
							$display("                 actual   %s", result_text(out_data));
						end
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_idx_t'(cfg_index))
					CFG_START_TH: start_th = cfg_data;
					CFG_STOP_TH:  stop_th  = cfg_data;
					CFG_AFTER:    after_n  = cfg_data[7:0];
					CFG_MAX:      max_len  = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall)
				track_command(in_data);
		end
		pending <= expected_actions.size();
	end

endmodule

[test/call_capture_segmenter_core_tb.sv]
// testbench top for the call capture segmenter: clock, reset, register writes,
// command stimulus with random idling; depends on ccs_pkg, the core and its checker
`timescale 1ns / 1ps

module call_capture_segmenter_core_tb;
	import ccs_pkg::*;

	localparam int RUN_LIMIT   = 400000;
	localparam int PHASES      = 8;
	localparam int PHASE_ITEMS = 58;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_item_t out_data;
	logic      cfg_valid;
	logic      cfg_ready;
	logic [1:0]  cfg_index;
	logic [11:0] cfg_data;

	int fail_count;
	int pending;
	int cycle_count;

	// set for phases where neither side idles
	bit steady;

	// register values last written, used to aim the envelope levels
	logic [11:0] cur_start, cur_stop;
	logic [7:0]  cur_after, cur_max;

	call_capture_segmenter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	call_capture_segmenter_core_checker segment_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 4 ns clock, first rising edge at 2 ns
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// run guard: a hung handshake or lost result ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("** call_capture_segmenter_core: FAILED **");
			$finish;
		end
	end

	// result side: before each transaction a random stall, none when steady, then wait for it
	initial begin
		int gap;
		out_stall = 1'b0;
		forever begin
			gap = steady ? 0 : $urandom_range(0, 17);
			if (gap != 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!(out_valid && !out_stall));
		end
	end

	// one command transaction; valid stays up across back-to-back transactions
	task automatic send_item(cmd_t cmd, logic [11:0] env, logic [31:0] tms);
		in_item_t it;
		int gap;
		it.command = cmd;
		it.envelope = env;
		it.time_ms = tms;
		gap = steady ? 0 : $urandom_range(0, 17);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (in_stall);
	endtask

	// sender holds off until every predicted result has been taken
	task automatic wait_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// one register write; the caller lowers cfg_valid after the last of a group
	task automatic write_reg(cfg_idx_t idx, logic [11:0] val);
		logic [11:0] data;
		data = val;
		// 8-bit registers get junk in the unused upper bits
		if (idx == CFG_AFTER || idx == CFG_MAX)
			data[11:8] = 4'($urandom_range(0, 15));
		case (idx)
			CFG_START_TH: cur_start = data;
			CFG_STOP_TH:  cur_stop  = data;
			CFG_AFTER:    cur_after = data[7:0];
			CFG_MAX:      cur_max   = data[7:0];
			default: ;
		endcase
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_levels(logic [11:0] start_lv, logic [11:0] stop_lv,
			logic [7:0] after_lv, logic [7:0] max_lv);
		wait_idle();
		write_reg(CFG_START_TH, start_lv);
		write_reg(CFG_STOP_TH, stop_lv);
		write_reg(CFG_AFTER, {4'd0, after_lv});
		write_reg(CFG_MAX, {4'd0, max_lv});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [11:0] loud_level();
		if (cur_start == 12'hFFF)
			return 12'hFFF;
		return 12'($urandom_range(4095, int'(cur_start) + 1));
	endfunction

	function automatic logic [11:0] quiet_level();
		return 12'($urandom_range(int'(cur_stop), 0));
	endfunction

	// anywhere between the two thresholds, inclusive
	function automatic logic [11:0] mid_level();
		return 12'($urandom_range(int'(cur_start), int'(cur_stop)));
	endfunction

	// bursts of loud frames between quiet stretches, releases and some noise mixed in
	task automatic run_phase(int release_pct);
		int loud_left;
		int quiet_left;
		int r;
		loud_left = 0;
		quiet_left = $urandom_range(0, 4);
		for (int k = 0; k < PHASE_ITEMS; k++) begin
			if (k > 0 && $urandom_range(0, 49) == 0)
				wait_idle();
			r = $urandom_range(0, 99);
			if (r < release_pct) begin
				send_item(CMD_RELEASE, 12'($urandom), $urandom);
			end else if (r < release_pct + 8) begin
				send_item(cmd_t'($urandom_range(0, 1)), 12'($urandom), $urandom);
			end else if (loud_left > 0) begin
				send_item(CMD_FRAME, loud_level(), $urandom);
				loud_left--;
			end else begin
				send_item(CMD_FRAME, ($urandom_range(0, 3) == 0) ? mid_level() : quiet_level(),
					$urandom);
				if (quiet_left > 0) begin
					quiet_left--;
				end else begin
					loud_left = $urandom_range(1, 6);
					quiet_left = $urandom_range(0, (cur_after > 8'd9) ? 12 : int'(cur_after) + 3);
				end
			end
		end
	endtask

	initial begin
		int release_pct;
		int lv;
		in_valid = 1'b0;
		in_data = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		steady = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: short hang so the call closes quickly
		set_levels(12'd1000, 12'd600, 8'd2, 8'd200);
		send_item(CMD_RELEASE, 12'd0, 32'd0);          // nothing finished yet
		send_item(CMD_FRAME, 12'd0, 32'd1);            // pre ring fills and wraps over five frames
		send_item(CMD_FRAME, 12'd600, 32'd2);          // level at stop threshold
		send_item(CMD_FRAME, 12'd1000, 32'd3);         // at start threshold, no start
		send_item(CMD_FRAME, 12'd0, 32'd4);
		send_item(CMD_FRAME, 12'd5, 32'd5);
		send_item(CMD_FRAME, 12'hFFF, 32'hFFFF_FFFF);  // start with a full pre ring
		send_item(CMD_FRAME, 12'd1001, 32'd0);         // hang count reset
		send_item(CMD_FRAME, 12'd601, 32'd0);
		send_item(CMD_FRAME, 12'd600, 32'd0);          // quiet frames counted
		send_item(CMD_FRAME, 12'd0, 32'd0);
		send_item(CMD_FRAME, 12'd0, 32'd0);            // hang runs out, call closes
		send_item(CMD_RELEASE, 12'hFFF, 32'hFFFF_FFFF);
		send_item(CMD_RELEASE, 12'd0, 32'd0);          // ring empty again
		send_item(CMD_FRAME, 12'hFFF, 32'd0);          // start with an empty pre ring
		send_item(CMD_FRAME, 12'd0, 32'd7);
		send_item(CMD_FRAME, 12'd0, 32'd8);
		send_item(CMD_FRAME, 12'd0, 32'd9);

		// maximum length zero: the call closes on the frame after its start
		wait_idle();
		write_reg(CFG_MAX, 12'd0);
		cfg_valid <= 1'b0;
		send_item(CMD_FRAME, 12'd2000, 32'h1234_5678);
		send_item(CMD_FRAME, 12'hFFF, 32'd0);
		send_item(CMD_RELEASE, 12'd0, 32'd0);
		send_item(CMD_RELEASE, 12'd0, 32'd0);
		send_item(CMD_RELEASE, 12'd0, 32'd0);

		// random phases, each with its own register setting
		for (int p = 0; p < PHASES; p++) begin
			steady = (p == 0 || p == 6);
			case (p)
				0: begin
					set_levels(12'd1000, 12'd600, 8'd10, 8'd200);
					release_pct = 12;
				end
				1: begin
					// lowest settings: any nonzero level starts a call
					set_levels(12'd0, 12'd0, 8'd0, 8'd1);
					release_pct = 10;
				end
				2: begin
					// long hang-driven calls run the call ring into overflow
					set_levels(12'd0, 12'hFFF, 8'd255, 8'd255);
					release_pct = 6;
				end
				3: begin
					// no level can start a call, leftovers get released
					set_levels(12'hFFF, 12'hFFF, 8'd0, 8'd255);
					release_pct = 25;
				end
				5: begin
					// short calls, rare releases: the descriptor ring fills up
					lv = $urandom_range(300, 3800);
					set_levels(12'(lv), 12'($urandom_range(lv, 0)), 8'($urandom_range(0, 1)),
						8'($urandom_range(1, 3)));
					release_pct = 2;
				end
				default: begin
					lv = $urandom_range(300, 3800);
					set_levels(12'(lv), 12'($urandom_range(lv, 0)), 8'($urandom_range(0, 8)),
						8'($urandom_range(1, 20)));
					release_pct = (p == 4) ? 20 : (p == 6) ? 35 : 8;
				end
			endcase
			run_phase(release_pct);
		end

		// drain and give late or extra results time to show up
		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("** call_capture_segmenter_core: PASSED **");
		else
			$display("** call_capture_segmenter_core: FAILED **");
		$finish;
	end

endmodule

[files.f]
+incdir+rtl
rtl/ccs_pkg.sv
rtl/ccs_front.sv
rtl/ccs_queue.sv
rtl/ccs_back.sv
rtl/call_capture_segmenter_core.sv
rtl/ccs_checker.sv
test/call_capture_segmenter_core_checker.sv
test/call_capture_segmenter_core_tb.sv
